>>> rtl/wrle_pkg.sv
// Package for the web request line extractor: types, codes and constants
// shared by the interfaces, the parser front, the record queue and the output stage.
// No dependencies.
package wrle_pkg;

   localparam int LINK_HEADER_BYTES_DEF = 14;
   localparam int QUEUE_DEPTH_DEF       = 4;

   // Frame position counter saturates; every position of interest lies below 256.
   localparam int POS_W       = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int PORT_W      = 16;
   localparam int ADDR_W      = 32;

   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [PORT_W-1:0]      port_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   typedef enum logic [2:0] {
      PH_LINK,
      PH_HEADERS,
      PH_METHOD,
      PH_PATH,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_COMPLETE,
      KIND_SECURE,
      KIND_CUT
   } kind_type;

   typedef enum logic [1:0] {
      METHOD_GET,
      METHOD_POST,
      METHOD_PUT
   } method_type;

   localparam csr_index_type CSR_WEB_PORT    = csr_index_type'(0);
   localparam csr_index_type CSR_SECURE_PORT = csr_index_type'(1);

   localparam port_type WEB_PORT_RESET    = 16'd80;
   localparam port_type SECURE_PORT_RESET = 16'd443;

   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [31:0] WORD_GET   = 32'h0047_4554;
   localparam logic [31:0] WORD_POST  = 32'h504F_5354;
   localparam logic [31:0] WORD_PUT   = 32'h0050_5554;

   localparam logic [3:0] HDR_LEN_MIN = 4'd5;

   // Byte offsets inside the IPv4 and TCP headers
   localparam int IP_DEST_FIRST  = 16;
   localparam int IP_DEST_LAST   = 19;
   localparam int TCP_PORT_HI    = 2;
   localparam int TCP_PORT_LO    = 3;
   localparam int TCP_DATA_OFFS  = 12;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] method;
      addr_type   dest_address;
      logic [7:0] path_char;
      logic       last;
   } rec_type;

endpackage

>>> rtl/wrle_if.sv
// Channel interfaces of the web request line extractor: frame bytes in,
// records out, and the register write port. Depends on wrle_pkg.

interface wrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface wrle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [1:0]  request_method;
   logic [31:0] dest_address;
   logic [7:0]  path_char;
   logic        record_last;

   modport source (output valid, output record_kind, output request_method,
                   output dest_address, output path_char, output record_last,
                   input ready);
   modport sink   (input valid, input record_kind, input request_method,
                   input dest_address, input path_char, input record_last,
                   output ready);
endinterface

interface wrle_csr_if;
   logic                     valid;
   logic                     ready;
   wrle_pkg::csr_index_type  reg_index;
   logic [15:0]              wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> rtl/wrle_front.sv
// Parser front: walks the frame header fields byte by byte, recognizes the
// method and emits at most one record per request. Depends on wrle_pkg.
module wrle_front #(
   parameter int LINK_HEADER_BYTES = wrle_pkg::LINK_HEADER_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         frame_byte,
   input  logic               frame_end,
   input  wrle_pkg::port_type web_port,
   input  wrle_pkg::port_type secure_port,
   output logic               rec_valid,
   output wrle_pkg::rec_type  rec
);

   localparam wrle_pkg::pos_type LH = wrle_pkg::pos_type'(LINK_HEADER_BYTES);

   wrle_pkg::phase_type phase_ff, phase_in;
   wrle_pkg::pos_type   pos_ff, pos_in;
   wrle_pkg::pos_type   tstart_ff, tstart_in;
   wrle_pkg::pos_type   pstart_ff, pstart_in;
   wrle_pkg::addr_type  addr_ff, addr_in;
   wrle_pkg::port_type  port_ff, port_in;
   logic [31:0]         mchars_ff, mchars_in;
   logic [2:0]          mcount_ff, mcount_in;
   logic [1:0]          method_ff, method_in;

   logic       is_space;
   logic       method_ok;
   logic [1:0] method_code;
   logic       at_ihl, at_offs, hdr_short, offs_short, in_payload;

   assign is_space   = (frame_byte == wrle_pkg::CHAR_SPACE);
   assign at_ihl     = (pos_ff == LH);
   assign at_offs    = (pos_ff == tstart_ff + wrle_pkg::pos_type'(wrle_pkg::TCP_DATA_OFFS));
   assign hdr_short  = (frame_byte[3:0] < wrle_pkg::HDR_LEN_MIN);
   assign offs_short = (frame_byte[7:4] < wrle_pkg::HDR_LEN_MIN);
   assign in_payload = (pos_ff >= pstart_ff);

   always_comb begin
      method_ok   = 1'b1;
      method_code = wrle_pkg::METHOD_GET;
      if (mcount_ff == 3'd3 && mchars_ff == wrle_pkg::WORD_GET) begin
         method_code = wrle_pkg::METHOD_GET;
      end else if (mcount_ff == 3'd4 && mchars_ff == wrle_pkg::WORD_POST) begin
         method_code = wrle_pkg::METHOD_POST;
      end else if (mcount_ff == 3'd3 && mchars_ff == wrle_pkg::WORD_PUT) begin
         method_code = wrle_pkg::METHOD_PUT;
      end else begin
         method_ok = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            wrle_pkg::PH_LINK: begin
               if (at_ihl) begin
                  phase_in = hdr_short ? wrle_pkg::PH_DONE : wrle_pkg::PH_HEADERS;
               end
            end
            wrle_pkg::PH_HEADERS: begin
               if (at_offs) begin
                  if (!offs_short && port_ff == web_port) begin
                     phase_in = wrle_pkg::PH_METHOD;
                  end else begin
                     phase_in = wrle_pkg::PH_DONE;
                  end
               end
            end
            wrle_pkg::PH_METHOD: begin
               if (in_payload) begin
                  if (is_space) begin
                     phase_in = method_ok ? wrle_pkg::PH_PATH : wrle_pkg::PH_DONE;
                  end else if (mcount_ff >= 3'd4) begin
                     phase_in = wrle_pkg::PH_DONE;
                  end
               end
            end
            wrle_pkg::PH_PATH: begin
               if (is_space) begin
                  phase_in = wrle_pkg::PH_DONE;
               end
            end
            default: ;
         endcase
         if (frame_end) begin
            phase_in = wrle_pkg::PH_LINK;
         end
      end
   end

   // datapath and record output
   always_comb begin
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      pstart_in = pstart_ff;
      addr_in   = addr_ff;
      port_in   = port_ff;
      mchars_in = mchars_ff;
      mcount_in = mcount_ff;
      method_in = method_ff;

      rec_valid        = 1'b0;
      rec.kind         = wrle_pkg::KIND_BYTE;
      rec.method       = method_ff;
      rec.dest_address = addr_ff;
      rec.path_char    = 8'h00;
      rec.last         = 1'b0;

      if (accept) begin
         case (phase_ff)
            wrle_pkg::PH_LINK: begin
               if (at_ihl) begin
                  tstart_in = LH + wrle_pkg::pos_type'({frame_byte[3:0], 2'b00});
               end
            end
            wrle_pkg::PH_HEADERS: begin
               if (pos_ff >= LH + wrle_pkg::pos_type'(wrle_pkg::IP_DEST_FIRST) &&
                   pos_ff <= LH + wrle_pkg::pos_type'(wrle_pkg::IP_DEST_LAST)) begin
                  addr_in = {addr_ff[23:0], frame_byte};
               end
               if (pos_ff == tstart_ff + wrle_pkg::pos_type'(wrle_pkg::TCP_PORT_HI) ||
                   pos_ff == tstart_ff + wrle_pkg::pos_type'(wrle_pkg::TCP_PORT_LO)) begin
                  port_in = {port_ff[7:0], frame_byte};
               end
               if (at_offs && !offs_short) begin
                  if (port_ff == web_port) begin
                     pstart_in = tstart_ff + wrle_pkg::pos_type'({frame_byte[7:4], 2'b00});
                  end else if (port_ff == secure_port) begin
                     rec_valid  = 1'b1;
                     rec.kind   = wrle_pkg::KIND_SECURE;
                     rec.method = 2'b00;
                     rec.last   = 1'b1;
                  end
               end
            end
            wrle_pkg::PH_METHOD: begin
               if (in_payload) begin
                  if (is_space) begin
                     if (method_ok) begin
                        method_in = method_code;
                        if (frame_end) begin
                           rec_valid  = 1'b1;
                           rec.kind   = wrle_pkg::KIND_CUT;
                           rec.method = method_code;
                           rec.last   = 1'b1;
                        end
                     end
                  end else if (mcount_ff < 3'd4) begin
                     mchars_in = {mchars_ff[23:0], frame_byte};
                     mcount_in = mcount_ff + 3'd1;
                  end
               end
            end
            wrle_pkg::PH_PATH: begin
               rec_valid = 1'b1;
               if (is_space) begin
                  rec.kind = wrle_pkg::KIND_COMPLETE;
                  rec.last = 1'b1;
               end else if (frame_end) begin
                  rec.kind = wrle_pkg::KIND_CUT;
                  rec.last = 1'b1;
               end else begin
                  rec.path_char = frame_byte;
               end
            end
            default: ;
         endcase

         if (pos_ff != '1) begin
            pos_in = pos_ff + wrle_pkg::pos_type'(1);
         end

         if (frame_end) begin
            pos_in    = '0;
            tstart_in = '0;
            pstart_in = '0;
            addr_in   = '0;
            port_in   = '0;
            mchars_in = '0;
            mcount_in = '0;
            method_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wrle_pkg::PH_LINK;
         pos_ff    <= '0;
         tstart_ff <= '0;
         pstart_ff <= '0;
         addr_ff   <= '0;
         port_ff   <= '0;
         mchars_ff <= '0;
         mcount_ff <= '0;
         method_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         pstart_ff <= pstart_in;
         addr_ff   <= addr_in;
         port_ff   <= port_in;
         mchars_ff <= mchars_in;
         mcount_ff <= mcount_in;
         method_ff <= method_in;
      end
   end

endmodule

>>> rtl/wrle_queue.sv
// Short record queue between the parser front and the output stage.
// Depends on wrle_pkg.
module wrle_queue #(
   parameter int DEPTH = wrle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wrle_pkg::rec_type push_data,
   input  logic              pop,
   output wrle_pkg::rec_type pop_data,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wrle_pkg::rec_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/wrle_back.sv
// Output stage: moves records from the queue into the response register
// and holds them until taken. Depends on wrle_pkg and wrle_if.
module wrle_back (
   input  logic              clock,
   input  logic              reset,
   input  wrle_pkg::rec_type q_data,
   input  logic              q_empty,
   output logic              q_pop,
   wrle_rsp_if.source        rsp_chan
);

   logic              out_valid_ff, out_valid_in;
   wrle_pkg::rec_type out_rec_ff, out_rec_in;
   logic              load;

   assign load  = !q_empty && (!out_valid_ff || rsp_chan.ready);
   assign q_pop = load;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rec_in   = out_rec_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_rec_in   = q_data;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff <= out_rec_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.record_kind    = out_rec_ff.kind;
   assign rsp_chan.request_method = out_rec_ff.method;
   assign rsp_chan.dest_address   = out_rec_ff.dest_address;
   assign rsp_chan.path_char      = out_rec_ff.path_char;
   assign rsp_chan.record_last    = out_rec_ff.last;

endmodule

>>> rtl/web_request_line_extractor.sv
// Web request line extractor. Takes one frame byte per cycle with no gaps needed
// between frames; each accepted byte yields at most one record, which goes via the
// queue and the response register to the response channel when the output is free. The
// parser front decides per byte and writes records into a small queue (QUEUE_DEPTH
// entries); the request side only stalls once that queue is full under response
// backpressure. The user must write port registers through the csr channel only while
// idle (unchecked). Depends on wrle_pkg, wrle_if, wrle_front, wrle_queue and wrle_back.
module web_request_line_extractor #(
   parameter int LINK_HEADER_BYTES = wrle_pkg::LINK_HEADER_BYTES_DEF,
   parameter int QUEUE_DEPTH       = wrle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wrle_req_if.sink    req_chan,
   wrle_rsp_if.source  rsp_chan,
   wrle_csr_if.sink    csr_chan
);

   wrle_pkg::port_type web_port_ff, web_port_in;
   wrle_pkg::port_type secure_port_ff, secure_port_in;

   logic              accept;
   logic              rec_valid;
   wrle_pkg::rec_type rec;
   wrle_pkg::rec_type q_data;
   logic              q_empty, q_full, q_pop;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      web_port_in    = web_port_ff;
      secure_port_in = secure_port_ff;
      if (csr_chan.valid) begin
         if (csr_chan.reg_index == wrle_pkg::CSR_WEB_PORT) begin
            web_port_in = csr_chan.wr_data;
         end else if (csr_chan.reg_index == wrle_pkg::CSR_SECURE_PORT) begin
            secure_port_in = csr_chan.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         web_port_ff    <= wrle_pkg::WEB_PORT_RESET;
         secure_port_ff <= wrle_pkg::SECURE_PORT_RESET;
      end else begin
         web_port_ff    <= web_port_in;
         secure_port_ff <= secure_port_in;
      end
   end

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   wrle_front #(
      .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_byte  (req_chan.frame_byte),
      .frame_end   (req_chan.frame_end),
      .web_port    (web_port_ff),
      .secure_port (secure_port_ff),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   wrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_data (rec),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   wrle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_data),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> bench/tb.sv
// Testbench for web_request_line_extractor: builds Ethernet/IPv4/TCP frames, streams
// them a byte per request, predicts the records and checks them under random idling.
// Depends on wrle_pkg, wrle_if and the RTL of the block.
module tb;

   localparam int LINK_HDR    = 14;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 10;

   // payload shapes for the frame builder
   localparam int PAY_GET   = 0;
   localparam int PAY_POST  = 1;
   localparam int PAY_PUT   = 2;
   localparam int PAY_HEAD  = 3;
   localparam int PAY_LONG  = 4;
   localparam int PAY_EMPTY = 5;
   localparam int PAY_LOWER = 6;
   localparam int PAY_JUNK  = 7;

   localparam logic [31:0] WORD_HEAD   = 32'h4845_4144;
   localparam logic [31:0] WORD_GET_LC = 32'h0067_6574;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } frame_octet_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wrle_req_if req_if ();
   wrle_rsp_if rsp_if ();
   wrle_csr_if csr_if ();

   web_request_line_extractor #(.LINK_HEADER_BYTES(LINK_HDR)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #10 clock = ~clock;

   // parser state mirror
   logic [15:0]         fp_pos;
   logic [7:0]          fp_tcp_start;
   logic [7:0]          fp_data_start;
   wrle_pkg::addr_type  fp_addr;
   wrle_pkg::port_type  fp_port;
   wrle_pkg::phase_type fp_phase;
   logic [31:0]         fp_word;
   logic [2:0]          fp_wlen;
   logic [1:0]          fp_method;
   wrle_pkg::port_type  cfg_web;
   wrle_pkg::port_type  cfg_secure;

   frame_octet_type   octets_waiting[$];
   wrle_pkg::rec_type records_due[$];
   logic [7:0]        frame_buf[$];
   logic [7:0]        payload_buf[$];

   int frames_built = 0;
   int octets_queued = 0;
   int records_seen = 0;
   int kind_count[4] = '{0, 0, 0, 0};
   int errors = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   int tx_idle_pct = 26;
   int rx_idle_pct = 66;
   int quiet_cycles = 0;

   function automatic void clear_parse_state();
      fp_pos        = '0;
      fp_tcp_start  = '0;
      fp_data_start = '0;
      fp_addr       = '0;
      fp_port       = '0;
      fp_phase      = wrle_pkg::PH_LINK;
      fp_word       = '0;
      fp_wlen       = '0;
      fp_method     = '0;
   endfunction

   // Advances the mirror by one frame byte; returns 1 when the byte yields a record.
   function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                     output wrle_pkg::rec_type rec);
      bit         has;
      bit         ok;
      logic [3:0] nib;
      int         pos;
      has = 1'b0;
      rec = '0;
      pos = int'(fp_pos);
      case (fp_phase)
         wrle_pkg::PH_LINK: begin
            if (pos == LINK_HDR) begin
               nib = b[3:0];
               if (nib < wrle_pkg::HDR_LEN_MIN) begin
                  fp_phase = wrle_pkg::PH_DONE;
               end else begin
                  fp_tcp_start = 8'(LINK_HDR + int'(nib) * 4);
                  fp_phase     = wrle_pkg::PH_HEADERS;
               end
            end
         end
         wrle_pkg::PH_HEADERS: begin
            if (pos >= LINK_HDR + wrle_pkg::IP_DEST_FIRST &&
                pos <= LINK_HDR + wrle_pkg::IP_DEST_LAST)
               fp_addr = {fp_addr[23:0], b};
            if (pos == int'(fp_tcp_start) + wrle_pkg::TCP_PORT_HI ||
                pos == int'(fp_tcp_start) + wrle_pkg::TCP_PORT_LO)
               fp_port = {fp_port[7:0], b};
            if (pos == int'(fp_tcp_start) + wrle_pkg::TCP_DATA_OFFS) begin
               nib = b[7:4];
               if (nib < wrle_pkg::HDR_LEN_MIN) begin
                  fp_phase = wrle_pkg::PH_DONE;
               end else if (fp_port == cfg_web) begin
                  fp_data_start = 8'(int'(fp_tcp_start) + int'(nib) * 4);
                  fp_phase      = wrle_pkg::PH_METHOD;
               end else if (fp_port == cfg_secure) begin
                  rec.kind         = wrle_pkg::KIND_SECURE;
                  rec.dest_address = fp_addr;
                  rec.last         = 1'b1;
                  has              = 1'b1;
                  fp_phase         = wrle_pkg::PH_DONE;
               end else begin
                  fp_phase = wrle_pkg::PH_DONE;
               end
            end
         end
         wrle_pkg::PH_METHOD: begin
            if (pos >= int'(fp_data_start)) begin
               if (b == wrle_pkg::CHAR_SPACE) begin
                  ok = 1'b1;
                  if (fp_wlen == 3'd3 && fp_word == wrle_pkg::WORD_GET)
                     fp_method = wrle_pkg::METHOD_GET;
                  else if (fp_wlen == 3'd4 && fp_word == wrle_pkg::WORD_POST)
                     fp_method = wrle_pkg::METHOD_POST;
                  else if (fp_wlen == 3'd3 && fp_word == wrle_pkg::WORD_PUT)
                     fp_method = wrle_pkg::METHOD_PUT;
                  else
                     ok = 1'b0;
                  fp_phase = ok ? wrle_pkg::PH_PATH : wrle_pkg::PH_DONE;
                  // frame ends on the space after the method
                  if (ok && fin) begin
                     rec.kind         = wrle_pkg::KIND_CUT;
                     rec.method       = fp_method;
                     rec.dest_address = fp_addr;
                     rec.last         = 1'b1;
                     has              = 1'b1;
                  end
               end else if (fp_wlen >= 3'd4) begin
                  fp_phase = wrle_pkg::PH_DONE;
               end else begin
                  fp_word = {fp_word[23:0], b};
                  fp_wlen = fp_wlen + 3'd1;
               end
            end
         end
         wrle_pkg::PH_PATH: begin
            has              = 1'b1;
            rec.method       = fp_method;
            rec.dest_address = fp_addr;
            if (b == wrle_pkg::CHAR_SPACE) begin
               rec.kind = wrle_pkg::KIND_COMPLETE;
               rec.last = 1'b1;
               fp_phase = wrle_pkg::PH_DONE;
            end else if (fin) begin
               rec.kind = wrle_pkg::KIND_CUT;
               rec.last = 1'b1;
            end else begin
               rec.kind      = wrle_pkg::KIND_BYTE;
               rec.path_char = b;
            end
         end
         default: ;
      endcase
      if (fp_pos != 16'hFFFF)
         fp_pos = fp_pos + 16'd1;
      if (fin)
         clear_parse_state();
      return has;
   endfunction

   task automatic push_word(input logic [31:0] w, input int n);
      for (int i = n - 1; i >= 0; i--)
         payload_buf.push_back(w[8*i +: 8]);
   endtask

   task automatic make_payload(input int shape, input int path_len, input bit close);
      logic [7:0] ch;
      int         n;
      payload_buf.delete();
      case (shape)
         PAY_GET:   push_word(wrle_pkg::WORD_GET, 3);
         PAY_POST:  push_word(wrle_pkg::WORD_POST, 4);
         PAY_PUT:   push_word(wrle_pkg::WORD_PUT, 3);
         PAY_HEAD:  push_word(WORD_HEAD, 4);
         PAY_LONG: begin
            push_word(wrle_pkg::WORD_POST, 4);
            payload_buf.push_back(8'h58);
         end
         PAY_EMPTY: ;
         PAY_LOWER: push_word(WORD_GET_LC, 3);
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) payload_buf.push_back(8'($urandom_range(65, 90)));
         end
      endcase
      payload_buf.push_back(wrle_pkg::CHAR_SPACE);
      repeat (path_len) begin
         ch = 8'($urandom);
         if (ch == wrle_pkg::CHAR_SPACE)
            ch = 8'h2F;
         payload_buf.push_back(ch);
      end
      if (close) begin
         payload_buf.push_back(wrle_pkg::CHAR_SPACE);
         repeat ($urandom_range(0, 6)) payload_buf.push_back(8'($urandom));
      end
   endtask

   function automatic int hdr_bytes(input int ihl, input int off);
      return LINK_HDR + ((ihl >= 5) ? ihl * 4 : 20) + ((off >= 5) ? off * 4 : 20);
   endfunction

   // keep > 0 cuts the frame to its first keep bytes
   task automatic add_frame(input int ihl, input wrle_pkg::addr_type addr,
                            input wrle_pkg::port_type port, input int off, input int keep);
      int              ip_len;
      int              tcp_len;
      int              n;
      frame_octet_type item;
      ip_len  = (ihl >= 5) ? ihl * 4 : 20;
      tcp_len = (off >= 5) ? off * 4 : 20;
      frame_buf.delete();
      repeat (LINK_HDR) frame_buf.push_back(8'($urandom));
      frame_buf.push_back({4'($urandom), 4'(ihl)});
      for (int i = 1; i < ip_len; i++) begin
         if (i >= wrle_pkg::IP_DEST_FIRST && i <= wrle_pkg::IP_DEST_LAST)
            frame_buf.push_back(addr[8*(wrle_pkg::IP_DEST_LAST-i) +: 8]);
         else
            frame_buf.push_back(8'($urandom));
      end
      for (int i = 0; i < tcp_len; i++) begin
         if (i == wrle_pkg::TCP_PORT_HI)
            frame_buf.push_back(port[15:8]);
         else if (i == wrle_pkg::TCP_PORT_LO)
            frame_buf.push_back(port[7:0]);
         else if (i == wrle_pkg::TCP_DATA_OFFS)
            frame_buf.push_back({4'(off), 4'($urandom)});
         else
            frame_buf.push_back(8'($urandom));
      end
      foreach (payload_buf[i]) frame_buf.push_back(payload_buf[i]);
      n = (keep > 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
      for (int i = 0; i < n; i++) begin
         item.data = frame_buf[i];
         item.fin  = (i == n - 1);
         octets_waiting.push_back(item);
      end
      octets_queued += n;
      frames_built++;
   endtask

   // Mostly well-formed web frames; the rest secure, bad methods, bad lengths, odd ports.
   task automatic random_frames(input int n_items);
      int                 start;
      int                 pick;
      int                 ihl;
      int                 off;
      int                 keep;
      int                 shape;
      int                 plen;
      wrle_pkg::port_type port;
      start = octets_queued;
      while (octets_queued - start < n_items) begin
         pick  = $urandom_range(0, 99);
         ihl   = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
         off   = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
         port  = cfg_web;
         shape = $urandom_range(PAY_GET, PAY_PUT);
         keep  = 0;
         if (pick >= 92) begin
            port = wrle_pkg::port_type'($urandom);
         end else if (pick >= 85) begin
            if ($urandom_range(0, 1) != 0)
               ihl = $urandom_range(0, 4);
            else
               off = $urandom_range(0, 4);
         end else if (pick >= 75) begin
            shape = $urandom_range(PAY_HEAD, PAY_JUNK);
         end else if (pick >= 60) begin
            port = cfg_secure;
         end
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         make_payload(shape, plen, $urandom_range(0, 4) != 0);
         if ($urandom_range(0, 6) == 0)
            keep = $urandom_range(1, hdr_bytes(ihl, off) + payload_buf.size());
         add_frame(ihl, wrle_pkg::addr_type'($urandom), port, off, keep);
      end
   endtask

   // wait until every request is taken and every record has come back
   task automatic drain();
      do @(posedge clock);
      while (octets_waiting.size() != 0 || req_if.valid || records_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input wrle_pkg::csr_index_type idx,
                            input wrle_pkg::port_type val);
      @(posedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == wrle_pkg::CSR_WEB_PORT)
         cfg_web = val;
      else if (idx == wrle_pkg::CSR_SECURE_PORT)
         cfg_secure = val;
   endtask

   // request driver
   always @(posedge clock) begin
      frame_octet_type   nx;
      wrle_pkg::rec_type rec;
      bit                has_rec;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            has_rec = parse_byte(req_if.frame_byte, req_if.frame_end, rec);
            if (has_rec)
               records_due.push_back(rec);
         end
         if (!req_if.valid || req_if.ready) begin
            if (octets_waiting.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               nx = octets_waiting.pop_front();
               req_if.valid      <= 1'b1;
               req_if.frame_byte <= nx.data;
               req_if.frame_end  <= nx.fin;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // record monitor and receiver stalls
   always @(posedge clock) begin
      wrle_pkg::rec_type got;
      wrle_pkg::rec_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind         = wrle_pkg::kind_type'(rsp_if.record_kind);
            got.method       = rsp_if.request_method;
            got.dest_address = rsp_if.dest_address;
            got.path_char    = rsp_if.path_char;
            got.last         = rsp_if.record_last;
            records_seen++;
            kind_count[got.kind]++;
            if (records_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected record kind %0d method %0d addr %h char %h last %0d",
                        $time, got.kind, got.method, got.dest_address, got.path_char,
                        got.last);
            end else begin
               want = records_due.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: expected kind %0d method %0d addr %h char %h last %0d",
                           $time, want.kind, want.method, want.dest_address,
                           want.path_char, want.last);
                  $display("%0t: actual   kind %0d method %0d addr %h char %h last %0d",
                           $time, got.kind, got.method, got.dest_address,
                           got.path_char, got.last);
               end
            end
         end
         if (hold_given != hold_asked) begin
            hold_left  = HOLD_CYCLES;
            hold_given = hold_given + 1;
         end
         if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("%0t: no handshake for %0d cycles, %0d records outstanding",
               $time, STALL_LIMIT, records_due.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      req_if.valid      = 1'b0;
      req_if.frame_byte = '0;
      req_if.frame_end  = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.reg_index  = '0;
      csr_if.wr_data    = '0;
      cfg_web           = wrle_pkg::WEB_PORT_RESET;
      cfg_secure        = wrle_pkg::SECURE_PORT_RESET;
      clear_parse_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset ports
      make_payload(PAY_GET, 2, 1);
      add_frame(5, 32'hC0A8_0001, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_POST, 5, 1);
      add_frame(5, 32'h0A00_0002, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_PUT, 4, 1);
      add_frame(6, 32'h7F00_0001, wrle_pkg::WEB_PORT_RESET, 8, 0);
      // empty path
      make_payload(PAY_GET, 0, 1);
      add_frame(5, 32'h0102_0304, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'hFFFF_FFFF, wrle_pkg::SECURE_PORT_RESET, 5, 0);
      // short IP and TCP headers
      make_payload(PAY_GET, 3, 1);
      add_frame(4, 32'h0A0A_0A0A, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_GET, 3, 1);
      add_frame(0, 32'h0A0A_0A0B, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'h0A0A_0A0C, wrle_pkg::WEB_PORT_RESET, 4, 0);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'h0A0A_0A0D, wrle_pkg::SECURE_PORT_RESET, 0, 0);
      // deepest payload start
      make_payload(PAY_POST, 6, 1);
      add_frame(15, 32'h8000_0001, wrle_pkg::WEB_PORT_RESET, 15, 0);
      // first words that are not a method
      make_payload(PAY_HEAD, 3, 1);
      add_frame(5, 32'h3333_3333, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_LONG, 3, 1);
      add_frame(5, 32'h4444_4444, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_EMPTY, 3, 1);
      add_frame(5, 32'h5555_5555, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_LOWER, 3, 1);
      add_frame(5, 32'h6666_6666, wrle_pkg::WEB_PORT_RESET, 5, 0);
      // frame end inside the path, on the method space, on the closing space
      make_payload(PAY_GET, 5, 1);
      add_frame(5, 32'h7777_7777, wrle_pkg::WEB_PORT_RESET, 5, hdr_bytes(5, 5) + 4 + 3);
      make_payload(PAY_PUT, 5, 1);
      add_frame(5, 32'h8888_8888, wrle_pkg::WEB_PORT_RESET, 5, hdr_bytes(5, 5) + 4);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'h9999_9999, wrle_pkg::WEB_PORT_RESET, 5,
                hdr_bytes(5, 5) + 4 + 3 + 1);
      // short frames: method without its space, one byte, cut in the headers
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'hAAAA_AAAA, wrle_pkg::WEB_PORT_RESET, 5, hdr_bytes(5, 5) + 3);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'hBBBB_BBBB, wrle_pkg::WEB_PORT_RESET, 5, 1);
      make_payload(PAY_GET, 3, 1);
      add_frame(5, 32'hCCCC_CCCC, wrle_pkg::SECURE_PORT_RESET, 5, hdr_bytes(5, 5) - 9);
      // long path runs the position counter past its top
      make_payload(PAY_GET, 200, 1);
      add_frame(5, 32'hDDDD_DDDD, wrle_pkg::WEB_PORT_RESET, 5, 0);
      make_payload(PAY_POST, 4, 1);
      add_frame(5, 32'hEEEE_EEEE, wrle_pkg::WEB_PORT_RESET, 5, 0);
      drain();

      write_csr(wrle_pkg::CSR_WEB_PORT, 16'h0000);
      write_csr(wrle_pkg::CSR_SECURE_PORT, 16'hFFFF);
      random_frames(40);
      drain();

      tx_idle_pct = 66;
      rx_idle_pct = 26;
      write_csr(wrle_pkg::CSR_WEB_PORT, 16'hFFFF);
      write_csr(wrle_pkg::CSR_SECURE_PORT, 16'h0000);
      random_frames(40);
      drain();

      // equal ports count as plain web; receiver holds off while requests pile up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_csr(wrle_pkg::CSR_WEB_PORT, 16'd8080);
      write_csr(wrle_pkg::CSR_SECURE_PORT, 16'd8080);
      hold_asked = hold_asked + 1;
      make_payload(PAY_GET, 20, 1);
      add_frame(5, 32'h1234_5678, 16'd8080, 5, 0);
      random_frames(60);
      drain();

      write_csr(wrle_pkg::CSR_WEB_PORT, wrle_pkg::port_type'($urandom));
      write_csr(wrle_pkg::CSR_SECURE_PORT, wrle_pkg::port_type'($urandom));
      random_frames(40);
      drain();

      $display("Covered %0d frames, %0d bytes, %0d records: %0d path bytes, ",
               frames_built, octets_queued, records_seen,
               kind_count[wrle_pkg::KIND_BYTE],
               "%0d complete, %0d secure, %0d cut",
               kind_count[wrle_pkg::KIND_COMPLETE], kind_count[wrle_pkg::KIND_SECURE],
               kind_count[wrle_pkg::KIND_CUT]);
      $display("Port settings: reset, both extremes swapped, equal and random; %0d mismatches",
               errors);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
